// ===== hdl/ssrsp_pkg.sv =====
`default_nettype none
package ssrsp_pkg;

	// attempt report fields
	typedef struct packed {
		logic [31:0] channel_key;
		logic        got_reply;
		logic        got_image;
	} att_t;

	// policy result fields
	typedef struct packed {
		logic       skip;
		logic       known_before;
		logic [7:0] streak_after;
	} res_t;

	// register map
	localparam int unsigned PADDR_BITS = 3;
	localparam logic REG_FAILURE_LIMIT = 1'b0;
	localparam logic REG_CHANNEL_TOTAL = 1'b1;

	// register reset values
	localparam logic [7:0] FAILURE_LIMIT_RST = 8'd3;
	localparam logic [9:0] CHANNEL_TOTAL_RST = 10'd0;

endpackage
`default_nettype wire

// ===== hdl/ssrsp_ram.sv =====
`default_nettype none
module ssrsp_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/seen_set_retry_skip_policy_unit.sv =====
`default_nettype none
// channel   | signals                          | direction
// ----------+----------------------------------+----------
// att       | att_valid, att_ready, att        | in
// res       | res_valid, res_ready, res        | out
// apb       | psel, penable, pwrite, paddr,    | in/out
//           | pwdata, prdata, pready           |
//
// an attempt walks the key ram over its n stored keys (n up to ENTRIES) with one shared
// comparator, one entry a cycle; the update step then loads the result and returns to idle,
// where the next attempt can be taken; a hit on entry j ends the walk early.
// a zero key or an empty set skips the walk and goes straight to the update step.
// reset clears control state and the fill count; the key ram itself is not cleared.
// a new attempt is taken while a result waits in the output register; the final
// update step holds while that register is still full.
module seen_set_retry_skip_policy_unit
	import ssrsp_pkg::*;
#(
	parameter int unsigned ENTRIES  = 16,
	parameter int unsigned KEY_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  att_valid,
	output logic                       att_ready,
	input  wire att_t                  att,
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output res_t                       res,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	localparam int unsigned KW = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_HOLD   = 4'b1000
	} state_t;

	state_t         state_q;
	logic [7:0]     limit_q;
	logic [9:0]     total_q;
	logic [KW-1:0]  key_q;
	logic           answered_q;
	logic           picture_q;
	logic           known_q;
	logic [CW-1:0]  idx_q;
	logic           cmp_vld_q;
	logic [CW-1:0]  count_q;
	logic [IW-1:0]  oldest_q;
	logic [7:0]     streak_q;
	logic           res_valid_q;
	res_t           res_q;

	logic [KW-1:0]  in_key;
	logic           att_xfer;
	logic           cfg_wr;
	logic           issue;
	logic           hit;
	logic           scan_done;
	logic [KW-1:0]  rd_key;
	logic           ram_we;
	logic [IW-1:0]  ram_waddr;
	logic           out_free;
	logic           set_full;
	logic [8:0]     streak_inc;
	logic [7:0]     streak_nxt;
	logic           skip_nxt;
	logic           add_key;

	assign in_key   = att.channel_key[KW-1:0];
	assign att_xfer = att_valid && att_ready;
	assign att_ready = (state_q == ST_IDLE);

	// apb register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_FAILURE_LIMIT: prdata = {24'd0, limit_q};
			REG_CHANNEL_TOTAL: prdata = {22'd0, total_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= FAILURE_LIMIT_RST;
			total_q <= CHANNEL_TOTAL_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FAILURE_LIMIT: limit_q <= pwdata[7:0];
				REG_CHANNEL_TOTAL: total_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// key walk: issue one read per cycle, compare the data from the previous read
	assign issue     = (state_q == ST_SCAN) && (idx_q != count_q) && !hit;
	assign hit       = cmp_vld_q && (rd_key == key_q);
	assign scan_done = hit || ((idx_q == count_q) && !cmp_vld_q);

	ssrsp_ram #(
		.WIDTH(KW),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(key_q),
		.raddr(idx_q[IW-1:0]),
		.rdata(rd_key)
	);

	// policy decision for the final step
	assign out_free   = !res_valid_q || res_ready;
	assign set_full   = (count_q == CW'(ENTRIES));
	assign streak_inc = {1'b0, streak_q} + 9'd1;
	assign add_key    = picture_q && (key_q != '0) && !known_q;
	assign ram_we     = (state_q == ST_UPDATE) && out_free && add_key;
	assign ram_waddr  = set_full ? oldest_q : count_q[IW-1:0];

	always_comb begin
		streak_nxt = streak_q;
		skip_nxt   = 1'b0;
		if (picture_q || !answered_q || known_q) begin
			streak_nxt = '0;
		end else if (total_q > 10'd1) begin
			if (streak_inc < {1'b0, limit_q}) begin
				streak_nxt = streak_inc[7:0];
			end else begin
				streak_nxt = '0;
				skip_nxt   = 1'b1;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			cmp_vld_q <= 1'b0;
			known_q   <= 1'b0;
			count_q   <= '0;
			oldest_q  <= '0;
			streak_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (att_xfer) begin
						idx_q     <= '0;
						cmp_vld_q <= 1'b0;
						known_q   <= 1'b0;
						if ((in_key == '0) || (count_q == '0)) begin
							state_q <= ST_UPDATE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					cmp_vld_q <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_done) begin
						known_q <= known_q | hit;
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (out_free) begin
						streak_q <= streak_nxt;
						if (add_key) begin
							if (set_full) begin
								oldest_q <= (oldest_q == IW'(ENTRIES - 1)) ? '0
									: oldest_q + 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				ST_HOLD: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// attempt payload capture
	always_ff @(posedge clk) begin
		if (att_xfer) begin
			key_q      <= in_key;
			answered_q <= att.got_reply;
			picture_q  <= att.got_image;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_UPDATE) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_UPDATE) && out_free) begin
			res_q.skip         <= skip_nxt;
			res_q.known_before <= known_q;
			res_q.streak_after <= streak_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("fill count beyond set size");

	a_skip_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.skip |-> res_q.streak_after == 8'd0)
		else $error("skip with nonzero streak");

	a_known_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.known_before |-> !res_q.skip)
		else $error("known key caused a skip");

	a_no_zero_store: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> key_q != '0 && !known_q)
		else $error("zero or known key written to set");

endmodule
`default_nettype wire
